@@ rtl/core/aes_pkg.sv @@
// Types, S-box and round functions shared by the AES-128 encrypt core.
package aes_pkg;

  localparam int unsigned NR = 10;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  typedef logic [127:0] aes_blk_t;

  localparam logic [7:0] REG_KEY_HIGH = 8'h00;
  localparam logic [7:0] REG_KEY_LOW  = 8'h08;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of the block sits at bits [127-8k -: 8]; byte index = row + 4*col
  function automatic aes_blk_t sub_shift(input aes_blk_t s);
    aes_blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic aes_blk_t mix_cols(input aes_blk_t s);
    aes_blk_t   t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // one step of the schedule: 128-bit round key to the next one
  function automatic aes_blk_t next_rk(input aes_blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96] ^ sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    t  = w3;
    return {w0, w1, w2, t};
  endfunction

endpackage

@@ rtl/core/aes_round.sv @@
// One registered AES round stage: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round #(
  parameter bit LAST = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  aes_pkg::aes_blk_t   st_i,
  input  aes_pkg::aes_blk_t   rk_i,
  output logic                vld_o,
  output aes_pkg::aes_blk_t   st_o
);
  import aes_pkg::*;

  logic     vld_r;
  aes_blk_t st_r, st_nxt, ss;

  always_comb begin
    ss = sub_shift(st_i);
    st_nxt = (LAST ? ss : mix_cols(ss)) ^ rk_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
endmodule

@@ rtl/core/aes128_block_encrypt.sv @@
// Top level of the pipelined AES-128 encrypt core with APB key registers.
// A block is taken at any clock edge where start is high and busy is low, so blocks can
// follow back to back. Its ciphertext is on out_data with out_valid high once it has
// passed one register for the initial key addition, then one register stage per round.
// out_valid strobes for one cycle and the receiver cannot stall it. Keys are written at
// 0x00 (key_high) and 0x08 (key_low). After reset and after every key write the round
// keys are expanded one per cycle, and busy stays high until all of them are written;
// a key change is used from the next accepted block on.
// Write keys only while no block is in the pipe.
module aes128_block_encrypt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  aes_pkg::aes_in_t in_data,
  output logic             out_valid,
  output aes_pkg::aes_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import aes_pkg::*;

  logic [63:0] key_hi_r, key_lo_r;
  aes_blk_t    rk_r [0:NR];
  aes_blk_t    kx_cur_r;
  logic [7:0]  kx_rc_r;
  logic [3:0]  kx_cnt_r;
  logic        kx_busy_r;
  aes_blk_t    new_key;
  aes_blk_t    kx_next;
  logic        wr;
  logic        wr_key;

  assign pready = 1'b1;
  assign busy   = kx_busy_r;
  assign wr     = psel && penable && pwrite;
  assign wr_key = wr && ({4'h0, paddr} == REG_KEY_HIGH || {4'h0, paddr} == REG_KEY_LOW);

  always_comb begin
    prdata = 64'h0;
    case ({4'h0, paddr})
      REG_KEY_HIGH: prdata = key_hi_r;
      REG_KEY_LOW:  prdata = key_lo_r;
      default:      prdata = 64'h0;
    endcase
  end

  // key as it will be after this request
  always_comb begin
    new_key = {key_hi_r, key_lo_r};
    if ({4'h0, paddr} == REG_KEY_HIGH) new_key = {pwdata, key_lo_r};
    if ({4'h0, paddr} == REG_KEY_LOW)  new_key = {key_hi_r, pwdata};
  end

  assign kx_next = next_rk(kx_cur_r, kx_rc_r);

  // schedule walks forward one round key per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r  <= 64'h0;
      key_lo_r  <= 64'h0;
      kx_cur_r  <= '0;
      rk_r[0]   <= '0;
      kx_rc_r   <= 8'h01;
      kx_cnt_r  <= 4'd1;
      kx_busy_r <= 1'b1;
    end else if (wr_key) begin
      if ({4'h0, paddr} == REG_KEY_HIGH) key_hi_r <= pwdata;
      else key_lo_r <= pwdata;
      kx_cur_r  <= new_key;
      rk_r[0]   <= new_key;
      kx_rc_r   <= 8'h01;
      kx_cnt_r  <= 4'd1;
      kx_busy_r <= 1'b1;
    end else if (kx_busy_r) begin
      rk_r[kx_cnt_r] <= kx_next;
      kx_cur_r       <= kx_next;
      kx_rc_r        <= xtime(kx_rc_r);
      if (kx_cnt_r == 4'(NR)) kx_busy_r <= 1'b0;
      else kx_cnt_r <= kx_cnt_r + 4'd1;
    end
  end

  // initial key addition stage
  logic     v0_r;
  aes_blk_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start && !busy;
  end
  always_ff @(posedge clk) begin
    s0_r <= {in_data.plain_high, in_data.plain_low} ^ rk_r[0];
  end

  logic     vl [0:NR];
  aes_blk_t sl [0:NR];
  assign vl[0] = v0_r;
  assign sl[0] = s0_r;

  for (genvar g = 1; g <= NR; g++) begin : g_rnd
    aes_round #(.LAST(g == NR)) u_rnd (
      .clk(clk), .rst_n(rst_n),
      .vld_i(vl[g-1]), .st_i(sl[g-1]), .rk_i(rk_r[g]),
      .vld_o(vl[g]), .st_o(sl[g])
    );
  end

  assign out_valid = vl[NR];
  assign out_data  = {sl[NR][127:64], sl[NR][63:0]};

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##1 v0_r) else $error("request not entered");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> ##10 out_valid) else $error("result lost in pipe");
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    !wr |=> $stable(key_hi_r) && $stable(key_lo_r)) else $error("key changed without write");
  a_bsy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_key |=> busy) else $error("schedule not restarted");
endmodule
